// ===== rtl/bseg_pkg.sv =====
package bseg_pkg;

  typedef enum logic [2:0] {
    PS_IDLE = 3'd0,
    PS_WAIT = 3'd1,
    PS_A    = 3'd2,
    PS_GAP  = 3'd3,
    PS_B    = 3'd4,
    PS_REST = 3'd5
  } pulse_state_t;

  typedef enum logic [2:0] {
    ES_IDLE    = 3'd0,
    ES_RISE    = 3'd1,
    ES_PLATEAU = 3'd2,
    ES_FALL    = 3'd3,
    ES_PAUSE   = 3'd4
  } env_state_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    SQ_IDLE = 3'd0,
    SQ_ENV  = 3'd1,
    SQ_DIV  = 3'd2,
    SQ_PUL  = 3'd3,
    SQ_OUT  = 3'd4
  } seq_state_t;

  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_AMPLITUDE = 3'd0;
  localparam logic [CFG_AW-1:0] REG_PULSE     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_GAP       = 3'd2;
  localparam logic [CFG_AW-1:0] REG_PERIOD    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_RISE      = 3'd4;
  localparam logic [CFG_AW-1:0] REG_PLATEAU   = 3'd5;
  localparam logic [CFG_AW-1:0] REG_FALL      = 3'd6;
  localparam logic [CFG_AW-1:0] REG_PAUSE     = 3'd7;
  localparam int unsigned CFG_DW = 24;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ===== rtl/bseg_divider.sv =====
module bseg_divider #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NW-1:0]        numer,
  input  logic [DW-1:0]        denom,
  output bseg_pkg::div_ctl_t   ctl,
  output logic [NW-1:0]        quot
);
  import bseg_pkg::*;

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [DW:0]   rem;
  logic [DW-1:0] den;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW:0]   shifted;
  logic          ge;

  assign shifted = {rem[DW-1:0], q[NW-1]};
  assign ge = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= numer;
      rem <= '0;
      den <= denom;
    end else if (busy) begin
      rem <= ge ? shifted - {1'b0, den} : shifted;
      q   <= {q[NW-2:0], ge};
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = done;
  assign quot      = q;
endmodule

// ===== rtl/biphasic_stimulus_envelope_generator.sv =====
// Channel | Handshake        | Payload
// in      | in_valid/in_stall | cmd, elapsed_us
// out     | out_valid/out_stall | first_*, second_*, first_phase, second_phase
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
// Start, stop, unused commands and zero ticks go straight to the output step.
// A nonzero tick runs an envelope step and a pulse step per channel, plus a
// divide for a channel in a ramp; both channels share one serial restoring
// divider, one quotient bit per cycle.
// Reset is synchronous and leaves both channels stopped with outputs off.
// A result waits in the output register; the next item is taken only once it
// has been transferred, so a stalled result adds its stall to the item.
module biphasic_stimulus_envelope_generator #(
  parameter int unsigned TIMER_WIDTH = 24,
  parameter int unsigned DAC_WIDTH   = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             cmd,
  input  logic [15:0]            elapsed_us,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   first_out_a,
  output logic                   first_out_b,
  output logic [7:0]             first_dac,
  output logic                   second_out_a,
  output logic                   second_out_b,
  output logic [7:0]             second_dac,
  output logic [2:0]             first_phase,
  output logic [2:0]             second_phase,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [bseg_pkg::CFG_AW-1:0] cfg_index,
  input  logic [bseg_pkg::CFG_DW-1:0] cfg_data
);
  import bseg_pkg::*;

  localparam int unsigned TW = TIMER_WIDTH;
  localparam int unsigned BW = (TW > 24) ? TW : 24;
  localparam int unsigned XW = BW + 2;
  localparam int unsigned NW = BW + DAC_WIDTH;
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};

  logic [7:0]  amplitude_code;
  logic [23:0] pulse_width_us, interphase_gap_us, pulse_period_us;
  logic [23:0] rise_time_us, plateau_time_us, fall_time_us, pause_time_us;

  pulse_state_t ps [2];
  env_state_t   es [2];
  logic [TW-1:0] ptim [2];
  logic [TW-1:0] etim [2];
  logic [7:0]    elev [2];
  logic          da [2], db [2];
  logic [7:0]    dd [2];

  seq_state_t   sq, sq_next;
  logic         ch, ch_next;
  logic [15:0]  dt;
  logic         busy;

  logic         div_start;
  div_ctl_t     div_ctl;
  logic [NW-1:0] div_numer, quot;
  logic [23:0]  div_denom;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude_code    <= 8'd0;
      pulse_width_us    <= 24'd200;
      interphase_gap_us <= 24'd100;
      pulse_period_us   <= 24'd20000;
      rise_time_us      <= 24'd500000;
      plateau_time_us   <= 24'd2000000;
      fall_time_us      <= 24'd500000;
      pause_time_us     <= 24'd2000000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_AMPLITUDE: amplitude_code    <= cfg_data[7:0];
        REG_PULSE:     pulse_width_us    <= cfg_data;
        REG_GAP:       interphase_gap_us <= cfg_data;
        REG_PERIOD:    pulse_period_us   <= cfg_data;
        REG_RISE:      rise_time_us      <= cfg_data;
        REG_PLATEAU:   plateau_time_us   <= cfg_data;
        REG_FALL:      fall_time_us      <= cfg_data;
        REG_PAUSE:     pause_time_us     <= cfg_data;
      endcase
    end
  end

  // Per-channel working values for the channel being processed.
  logic [TW:0]   psum, esum;
  logic [TW-1:0] pt_sat, et_sat;
  logic [XW-1:0] used_w, lim_wait_w;
  logic [TW-1:0] lim_wait;
  logic [XW-1:0] lim_rest, lim_pw, lim_gap, pt_w;

  assign psum   = {1'b0, ptim[ch]} + (TW+1)'(dt);
  assign esum   = {1'b0, etim[ch]} + (TW+1)'(dt);
  assign pt_sat = psum[TW] ? TMAX : psum[TW-1:0];
  assign et_sat = esum[TW] ? TMAX : esum[TW-1:0];

  function automatic logic [TW-1:0] clampt(input logic [XW-1:0] v);
    clampt = (v > XW'(TMAX)) ? TMAX : v[TW-1:0];
  endfunction

  assign lim_pw    = XW'(pulse_width_us);
  assign lim_gap   = XW'(interphase_gap_us);
  assign used_w    = (XW'(pulse_width_us) << 1) + XW'(interphase_gap_us);
  assign lim_wait  = clampt(used_w);
  assign lim_wait_w = XW'(pulse_period_us);
  assign lim_rest  = (lim_wait_w > used_w) ? lim_wait_w - used_w : '0;
  assign pt_w      = XW'(ptim[ch]);

  // Comparisons use full-width values so that timers of any width work.
  logic [XW-1:0] et_w;
  assign et_w = XW'(et_sat);

  bseg_divider #(.NW(NW), .DW(24)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(div_numer),
    .denom(div_denom), .ctl(div_ctl), .quot(quot)
  );

  logic [XW-1:0] fall_left;
  assign fall_left = XW'(fall_time_us) - et_w;

  always_comb begin
    div_numer = '0;
    div_denom = rise_time_us;
    if (es[ch] == ES_RISE) begin
      div_numer = NW'(et_sat) * NW'(amplitude_code);
    end else begin
      div_numer = NW'(fall_left) * NW'(amplitude_code);
      div_denom = fall_time_us;
    end
  end

  logic need_div;
  always_comb begin
    need_div = 1'b0;
    if (es[ch] == ES_RISE && et_w < XW'(rise_time_us)) need_div = 1'b1;
    if (es[ch] == ES_FALL && et_w < XW'(fall_time_us)) need_div = 1'b1;
  end

  logic accept;
  assign busy     = (sq != SQ_IDLE) || out_valid;
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) sq <= SQ_IDLE;
    else     sq <= sq_next;
    ch <= ch_next;
  end

  always_comb begin
    sq_next   = sq;
    ch_next   = ch;
    div_start = 1'b0;
    unique case (sq)
      SQ_IDLE: begin
        ch_next = 1'b0;
        if (accept) begin
          if (cmd == CMD_TICK && elapsed_us != 16'd0) sq_next = SQ_ENV;
          else sq_next = SQ_OUT;
        end
      end
      SQ_ENV: begin
        if (need_div) begin
          div_start = 1'b1;
          sq_next   = SQ_DIV;
        end else begin
          sq_next = SQ_PUL;
        end
      end
      SQ_DIV: if (div_ctl.done) sq_next = SQ_PUL;
      SQ_PUL: begin
        if (ch) sq_next = SQ_OUT;
        else begin
          ch_next = 1'b1;
          sq_next = SQ_ENV;
        end
      end
      SQ_OUT:  sq_next = SQ_IDLE;
      default: sq_next = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dt    <= elapsed_us;
    end
  end

  // Envelope step: timer and state in SQ_ENV, level once the divide is done.
  // Pulse step in SQ_PUL uses the envelope result already stored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        ps[i] <= PS_IDLE;
        es[i] <= ES_IDLE;
        ptim[i] <= '0;
        etim[i] <= '0;
        elev[i] <= '0;
        da[i] <= 1'b0;
        db[i] <= 1'b0;
        dd[i] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (sq == SQ_IDLE && accept) begin
        if (cmd == CMD_START) begin
          ps[0] <= PS_A;    es[0] <= ES_RISE;
          ps[1] <= PS_WAIT; es[1] <= ES_IDLE;
          for (int i = 0; i < 2; i++) begin
            ptim[i] <= '0; etim[i] <= '0; elev[i] <= '0;
          end
        end else if (cmd == CMD_STOP) begin
          for (int i = 0; i < 2; i++) begin
            ps[i] <= PS_IDLE; es[i] <= ES_IDLE;
            ptim[i] <= '0; etim[i] <= '0; elev[i] <= '0;
            da[i] <= 1'b0; db[i] <= 1'b0; dd[i] <= '0;
          end
        end
      end
      if (sq == SQ_ENV) begin
        ptim[ch] <= pt_sat;
        etim[ch] <= et_sat;
        unique case (es[ch])
          ES_RISE: if (!need_div) begin
            etim[ch] <= '0; es[ch] <= ES_PLATEAU; elev[ch] <= amplitude_code;
          end
          ES_PLATEAU: begin
            elev[ch] <= amplitude_code;
            if (et_w >= XW'(plateau_time_us)) begin
              etim[ch] <= '0; es[ch] <= ES_FALL;
            end
          end
          ES_FALL: if (!need_div) begin
            etim[ch] <= '0; es[ch] <= ES_PAUSE; elev[ch] <= '0;
          end
          ES_PAUSE: begin
            elev[ch] <= '0;
            if (et_w >= XW'(pause_time_us)) begin
              etim[ch] <= '0; es[ch] <= ES_RISE;
              ps[ch] <= PS_A; ptim[ch] <= '0;
            end
          end
          default: begin
            es[ch] <= ES_IDLE; elev[ch] <= '0; etim[ch] <= '0;
          end
        endcase
      end
      if (sq == SQ_DIV && div_ctl.done) elev[ch] <= quot[7:0];
      if (sq == SQ_PUL) begin
        if (es[ch] == ES_PAUSE) begin
          da[ch] <= 1'b0; db[ch] <= 1'b0; dd[ch] <= '0;
        end else begin
          unique case (ps[ch])
            PS_WAIT: begin
              da[ch] <= 1'b0; db[ch] <= 1'b0; dd[ch] <= '0;
              if (ptim[ch] >= lim_wait) begin
                ps[ch] <= PS_A; ptim[ch] <= '0; es[ch] <= ES_RISE;
                etim[ch] <= '0; elev[ch] <= '0;
              end
            end
            PS_A: begin
              if (pt_w >= lim_pw) begin
                da[ch] <= 1'b0; db[ch] <= 1'b0; dd[ch] <= '0;
                ps[ch] <= PS_GAP; ptim[ch] <= '0;
              end else begin
                da[ch] <= 1'b1; db[ch] <= 1'b0; dd[ch] <= elev[ch];
              end
            end
            PS_GAP: begin
              da[ch] <= 1'b0; db[ch] <= 1'b0; dd[ch] <= '0;
              if (pt_w >= lim_gap) begin
                ps[ch] <= PS_B; ptim[ch] <= '0;
              end
            end
            PS_B: begin
              if (pt_w >= lim_pw) begin
                da[ch] <= 1'b0; db[ch] <= 1'b0; dd[ch] <= '0;
                ps[ch] <= PS_REST; ptim[ch] <= '0;
              end else begin
                da[ch] <= 1'b0; db[ch] <= 1'b1; dd[ch] <= elev[ch];
              end
            end
            PS_REST: begin
              da[ch] <= 1'b0; db[ch] <= 1'b0; dd[ch] <= '0;
              if (pt_w >= lim_rest) begin
                ps[ch] <= PS_A; ptim[ch] <= '0;
              end
            end
            default: begin
              da[ch] <= 1'b0; db[ch] <= 1'b0; dd[ch] <= '0;
              ps[ch] <= PS_IDLE;
            end
          endcase
        end
      end
      if (sq == SQ_OUT) out_valid <= 1'b1;
    end
  end

  assign first_out_a  = da[0];
  assign first_out_b  = db[0];
  assign first_dac    = dd[0];
  assign second_out_a = da[1];
  assign second_out_b = db[1];
  assign second_dac   = dd[1];
  assign first_phase  = ps[0];
  assign second_phase = ps[1];

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (sq != SQ_IDLE) |-> in_stall) else $error("input taken while busy");
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_ctl.done |-> (sq == SQ_DIV)) else $error("stray divider result");
  a_div_busy_in_div: assert property (@(posedge clk) disable iff (rst)
    div_ctl.busy |-> (sq == SQ_DIV && !div_ctl.start)) else $error("divider out of step");
  a_out_after_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(sq == SQ_OUT)) else $error("result out of sequence");
endmodule
